// File: src/tos_pkg.sv
package tos_pkg;

	localparam int unsigned DEPTH_DEF = 64;
	localparam int unsigned OP_W = 3;
	localparam int unsigned TAG_W = 2;
	localparam int unsigned WORD_W = 64;
	localparam int unsigned ST_W = 2;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
	localparam logic [OP_W-1:0] OP_POP   = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
	localparam logic [OP_W-1:0] OP_DUP   = 3'd3;
	localparam logic [OP_W-1:0] OP_SWAP  = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

	// status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

	// write kind carried by the operation in flight
	localparam int unsigned WK_W = 2;
	localparam logic [WK_W-1:0] WK_NONE = 2'd0;
	localparam logic [WK_W-1:0] WK_PUSH = 2'd1;
	localparam logic [WK_W-1:0] WK_DUP  = 2'd2;
	localparam logic [WK_W-1:0] WK_SWAP = 2'd3;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [WORD_W-1:0] word;
	} entry_t;

endpackage

// File: src/tagged_operand_stack.sv
// Tagged operand stack: a LIFO of DEPTH entries, each a 2-bit type tag and a
// 64-bit word. Each input transaction carries one operation (push, pop, peek
// at a depth, duplicate top, swap two entries by depth, clear) and yields
// exactly one output transaction with the tag and word read (pop and peek
// only, zero otherwise), a status code and the entry count afterwards.
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low. out_valid rises once an accepted operation has passed the
// read stage into the output register. Throughput is one transaction per
// cycle while the receiver does not stall, for every operation except swap,
// which writes its first entry before leaving the read stage: the entry
// storage has a single write port, and a swap writes two entries.
// Failed operations (pop or dup on empty, push or dup on full, peek or swap
// out of range) report a status and leave the stack unchanged.
// Reset clears the entry count and empties the pipeline; the entry storage
// is not cleared and needs no sweep, since only pushed entries are read.
// When the receiver stalls, the result holds in the output register, the
// next operation waits in the read stage and in_stall rises behind it.
module tagged_operand_stack #(
	parameter int unsigned DEPTH = tos_pkg::DEPTH_DEF,
	parameter int unsigned AW = $clog2(DEPTH),
	parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [tos_pkg::OP_W-1:0]   op,
	input  logic [tos_pkg::TAG_W-1:0]  value_tag,
	input  logic [tos_pkg::WORD_W-1:0] value_word,
	input  logic [AW-1:0]              index_a,
	input  logic [AW-1:0]              index_b,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [tos_pkg::TAG_W-1:0]  out_tag,
	output logic [tos_pkg::WORD_W-1:0] out_word,
	output logic [tos_pkg::ST_W-1:0]   status,
	output logic [CNT_W-1:0]           depth_now
);

	// entry count, updated as soon as an operation is accepted
	logic [CNT_W-1:0] top_q;

	// read stage
	logic                     s1_v_q;
	logic                     swp_ph_q;
	logic [tos_pkg::WK_W-1:0] wk_s1;
	logic [tos_pkg::ST_W-1:0] st_s1;
	logic [CNT_W-1:0]         depth_s1;
	logic                     show_s1;
	logic [AW-1:0]            wa_s1;
	logic [AW-1:0]            wb_s1;
	tos_pkg::entry_t          push_s1;
	logic                     hit_a_s1;
	logic                     hit_b_s1;
	tos_pkg::entry_t          fwd_s1;

	// output register
	logic                        out_valid_q;
	logic [tos_pkg::TAG_W-1:0]   out_tag_q;
	logic [tos_pkg::WORD_W-1:0]  out_word_q;
	logic [tos_pkg::ST_W-1:0]    status_q;
	logic [CNT_W-1:0]            depth_q;

	logic acc;
	logic adv;

	// decode of the incoming operation
	logic [CNT_W-1:0]         top_m1;
	logic [CNT_W-1:0]         slot_a;
	logic [CNT_W-1:0]         slot_b;
	logic                     ia_ok;
	logic                     ib_ok;
	logic                     is_full;
	logic                     is_empty;
	logic [tos_pkg::ST_W-1:0] st_d;
	logic [tos_pkg::WK_W-1:0] wk_d;
	logic                     show_d;
	logic [CNT_W-1:0]         top_d;
	logic [AW-1:0]            ra_d;
	logic [AW-1:0]            rb_d;
	logic [AW-1:0]            wa_d;
	logic [AW-1:0]            wb_d;

	// storage ports
	logic            we;
	logic [AW-1:0]   waddr;
	tos_pkg::entry_t wdata;
	tos_pkg::entry_t rdata_a;
	tos_pkg::entry_t rdata_b;
	tos_pkg::entry_t rd_a;
	tos_pkg::entry_t rd_b;

	assign acc = in_valid && !in_stall;
	// a swap writes its first entry before it may leave the stage
	assign adv = s1_v_q && !(wk_s1 == tos_pkg::WK_SWAP && !swp_ph_q)
		&& (!out_valid_q || !out_stall);
	assign in_stall = s1_v_q && !adv;

	always_comb begin
		top_m1   = top_q - CNT_W'(1);
		slot_a   = top_m1 - CNT_W'(index_a);
		slot_b   = top_m1 - CNT_W'(index_b);
		ia_ok    = CNT_W'(index_a) < top_q;
		ib_ok    = CNT_W'(index_b) < top_q;
		is_full  = top_q == CNT_W'(DEPTH);
		is_empty = top_q == '0;
		st_d     = tos_pkg::ST_OK;
		wk_d     = tos_pkg::WK_NONE;
		show_d   = 1'b0;
		top_d    = top_q;
		ra_d     = top_m1[AW-1:0];
		rb_d     = slot_b[AW-1:0];
		wa_d     = top_q[AW-1:0];
		wb_d     = slot_b[AW-1:0];
		case (op)
			tos_pkg::OP_PUSH: begin
				if (is_full) begin
					st_d = tos_pkg::ST_FULL;
				end else begin
					wk_d  = tos_pkg::WK_PUSH;
					top_d = top_q + CNT_W'(1);
				end
			end
			tos_pkg::OP_POP: begin
				if (is_empty) begin
					st_d = tos_pkg::ST_EMPTY;
				end else begin
					show_d = 1'b1;
					top_d  = top_m1;
				end
			end
			tos_pkg::OP_PEEK: begin
				ra_d = slot_a[AW-1:0];
				if (!ia_ok) begin
					st_d = tos_pkg::ST_RANGE;
				end else begin
					show_d = 1'b1;
				end
			end
			tos_pkg::OP_DUP: begin
				if (is_empty) begin
					st_d = tos_pkg::ST_EMPTY;
				end else if (is_full) begin
					st_d = tos_pkg::ST_FULL;
				end else begin
					wk_d  = tos_pkg::WK_DUP;
					top_d = top_q + CNT_W'(1);
				end
			end
			tos_pkg::OP_SWAP: begin
				ra_d = slot_a[AW-1:0];
				wa_d = slot_a[AW-1:0];
				if (!(ia_ok && ib_ok)) begin
					st_d = tos_pkg::ST_RANGE;
				end else begin
					wk_d = tos_pkg::WK_SWAP;
				end
			end
			tos_pkg::OP_CLEAR: begin
				top_d = '0;
			end
			default: begin
			end
		endcase
	end

	// merge the write that landed on the same edge as the read
	assign rd_a = hit_a_s1 ? fwd_s1 : rdata_a;
	assign rd_b = hit_b_s1 ? fwd_s1 : rdata_b;

	// single write port: push and dup write as they leave; swap writes entry a
	// on its first cycle and entry b as it leaves
	always_comb begin
		we    = 1'b0;
		waddr = wa_s1;
		wdata = push_s1;
		case (wk_s1)
			tos_pkg::WK_PUSH: begin
				we = adv;
			end
			tos_pkg::WK_DUP: begin
				we    = adv;
				wdata = rd_a;
			end
			tos_pkg::WK_SWAP: begin
				we    = s1_v_q && (!swp_ph_q || adv);
				waddr = swp_ph_q ? wb_s1 : wa_s1;
				wdata = swp_ph_q ? rd_a : rd_b;
			end
			default: begin
			end
		endcase
	end

	tos_mem #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.re(acc),
		.raddr_a(ra_d),
		.raddr_b(rb_d),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q       <= '0;
			s1_v_q      <= 1'b0;
			swp_ph_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				top_q <= top_d;
			end
			if (acc) begin
				s1_v_q <= 1'b1;
			end else if (adv) begin
				s1_v_q <= 1'b0;
			end
			if (s1_v_q && wk_s1 == tos_pkg::WK_SWAP && !swp_ph_q) begin
				swp_ph_q <= 1'b1;
			end else if (adv) begin
				swp_ph_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// read stage payload: load on acceptance
	always_ff @(posedge clk) begin
		if (acc) begin
			wk_s1         <= wk_d;
			st_s1         <= st_d;
			depth_s1      <= top_d;
			show_s1       <= show_d;
			wa_s1         <= wa_d;
			wb_s1         <= wb_d;
			push_s1.tag   <= value_tag;
			push_s1.word  <= value_word;
			hit_a_s1      <= we && waddr == ra_d;
			hit_b_s1      <= we && waddr == rb_d;
			fwd_s1        <= wdata;
		end
	end

	// output payload: advance from the read stage, hold while stalled
	always_ff @(posedge clk) begin
		if (adv) begin
			out_tag_q  <= show_s1 ? rd_a.tag : '0;
			out_word_q <= show_s1 ? rd_a.word : '0;
			status_q   <= st_s1;
			depth_q    <= depth_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_tag   = out_tag_q;
	assign out_word  = out_word_q;
	assign status    = status_q;
	assign depth_now = depth_q;

	// entry count never exceeds the capacity
	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= CNT_W'(DEPTH))
		else $error("entry count above capacity");

	// every write lands on a slot that is held by the stack
	a_write_held: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> CNT_W'(waddr) < top_q)
		else $error("write outside the held entries");

	// a push accepted on a full stack reports overflow
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op == tos_pkg::OP_PUSH && top_q == CNT_W'(DEPTH))
		|=> (st_s1 == tos_pkg::ST_FULL && wk_s1 == tos_pkg::WK_NONE))
		else $error("push on full stack not flagged");

	// a swap stalls the input while it writes its first entry
	a_swap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v_q && wk_s1 == tos_pkg::WK_SWAP && !swp_ph_q) |-> in_stall)
		else $error("input taken during swap first write");

endmodule

// File: src/tos_mem.sv
module tos_mem #(
	parameter int unsigned DEPTH = tos_pkg::DEPTH_DEF,
	parameter int unsigned AW = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  tos_pkg::entry_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr_a,
	input  logic [AW-1:0]   raddr_b,
	output tos_pkg::entry_t rdata_a,
	output tos_pkg::entry_t rdata_b
);

	tos_pkg::entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered reads return the contents before a same-edge write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

// File: tb/sv/tb.sv
module tb;
	import tos_pkg::*;

	localparam int unsigned STACK_DEPTH = DEPTH_DEF;
	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

	// op codes the block must ignore
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	// cycles with no transaction on either channel before the run is abandoned
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	// length of the long receiver hold-off in the backpressure test
	localparam int unsigned HOLD_CYCLES = 400;
	// settle time after the last result
	localparam int unsigned SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [WORD_W-1:0] word;
		logic [ST_W-1:0]   st;
		logic [CNT_W-1:0]  depth;
	} stack_result_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [OP_W-1:0]     op;
	logic [TAG_W-1:0]    value_tag;
	logic [WORD_W-1:0]   value_word;
	logic [AW-1:0]       index_a;
	logic [AW-1:0]       index_b;
	logic                out_valid;
	logic                out_stall;
	logic [TAG_W-1:0]    out_tag;
	logic [WORD_W-1:0]   out_word;
	logic [ST_W-1:0]     status;
	logic [CNT_W-1:0]    depth_now;

	tagged_operand_stack #(
		.DEPTH(STACK_DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.value_tag  (value_tag),
		.value_word (value_word),
		.index_a    (index_a),
		.index_b    (index_b),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_tag    (out_tag),
		.out_word   (out_word),
		.status     (status),
		.depth_now  (depth_now)
	);

	// Shadow copy of the stack, advanced once per accepted input transaction.
	logic [TAG_W-1:0]  shadow_tag [STACK_DEPTH];
	logic [WORD_W-1:0] shadow_word [STACK_DEPTH];
	int unsigned       shadow_count = 0;

	// Results owed by the block, oldest first.
	stack_result_t pending_results[$];

	int unsigned mismatches = 0;
	int unsigned ops_sent = 0;
	int unsigned results_checked = 0;
	int unsigned status_seen [4] = '{default: 0};

	// Idle knobs, in percent per cycle; read by the driver and the receiver.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	// Hold-off requests from the tests; the receiver starts one per request.
	int unsigned hold_reqs = 0;
	int unsigned hold_taken = 0;
	// Remaining cycles of a forced receiver hold-off.
	int unsigned hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Compute the result of one operation and advance the shadow stack.
	// A failed operation leaves the shadow state alone.
	function automatic stack_result_t predict_stack_result(
		input logic [OP_W-1:0]   code,
		input logic [TAG_W-1:0]  tag,
		input logic [WORD_W-1:0] word,
		input logic [AW-1:0]     ia,
		input logic [AW-1:0]     ib
	);
		stack_result_t     r;
		int unsigned       sa;
		int unsigned       sb;
		logic [TAG_W-1:0]  t;
		logic [WORD_W-1:0] w;
		r = '0;
		r.st = ST_OK;
		case (code)
			OP_PUSH: begin
				if (shadow_count >= STACK_DEPTH) begin
					r.st = ST_FULL;
				end else begin
					shadow_tag[shadow_count] = tag;
					shadow_word[shadow_count] = word;
					shadow_count++;
				end
			end
			OP_POP: begin
				if (shadow_count == 0) begin
					r.st = ST_EMPTY;
				end else begin
					shadow_count--;
					r.tag = shadow_tag[shadow_count];
					r.word = shadow_word[shadow_count];
				end
			end
			OP_PEEK: begin
				if (ia >= shadow_count) begin
					r.st = ST_RANGE;
				end else begin
					sa = shadow_count - 1 - ia;
					r.tag = shadow_tag[sa];
					r.word = shadow_word[sa];
				end
			end
			OP_DUP: begin
				if (shadow_count == 0) begin
					r.st = ST_EMPTY;
				end else if (shadow_count >= STACK_DEPTH) begin
					r.st = ST_FULL;
				end else begin
					shadow_tag[shadow_count] = shadow_tag[shadow_count - 1];
					shadow_word[shadow_count] = shadow_word[shadow_count - 1];
					shadow_count++;
				end
			end
			OP_SWAP: begin
				if (ia >= shadow_count || ib >= shadow_count) begin
					r.st = ST_RANGE;
				end else begin
					sa = shadow_count - 1 - ia;
					sb = shadow_count - 1 - ib;
					t = shadow_tag[sa];
					w = shadow_word[sa];
					shadow_tag[sa] = shadow_tag[sb];
					shadow_word[sa] = shadow_word[sb];
					shadow_tag[sb] = t;
					shadow_word[sb] = w;
				end
			end
			OP_CLEAR: begin
				shadow_count = 0;
			end
			default: begin
			end
		endcase
		r.depth = shadow_count[CNT_W-1:0];
		status_seen[r.st]++;
		return r;
	endfunction

	// Offer one input transaction and hold it until the block takes it.
	// Idle cycles go in front of the offer; valid is dropped only for them.
	task automatic send_op(
		input logic [OP_W-1:0]   code,
		input logic [TAG_W-1:0]  tag,
		input logic [WORD_W-1:0] word,
		input logic [AW-1:0]     ia,
		input logic [AW-1:0]     ib
	);
		@(negedge clk);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		op <= code;
		value_tag <= tag;
		value_word <= word;
		index_a <= ia;
		index_b <= ib;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(predict_stack_result(code, tag, word, ia, ib));
		ops_sent++;
	endtask

	// Drop valid after the last transaction, then wait out every owed result.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly a depth that is held now, sometimes any index at all.
	function automatic logic [AW-1:0] pick_index();
		if (shadow_count > 0 && $urandom_range(3) != 0)
			return AW'($urandom_range(shadow_count - 1));
		return AW'($urandom_range(STACK_DEPTH - 1));
	endfunction

	// One random operation. While filling, pushes and dups dominate so the
	// stack reaches full; while draining, pops dominate so it hits empty.
	task automatic send_random_op(input bit filling);
		int unsigned       r;
		int unsigned       k;
		logic [OP_W-1:0]   code;
		logic [WORD_W-1:0] word;
		r = $urandom_range(99);
		if (filling) begin
			if (r < 55)      code = OP_PUSH;
			else if (r < 65) code = OP_DUP;
			else if (r < 75) code = OP_POP;
			else if (r < 85) code = OP_PEEK;
			else if (r < 94) code = OP_SWAP;
			else if (r < 95) code = OP_CLEAR;
			else if (r < 96) code = OP_SPARE_LO;
			else if (r < 97) code = OP_SPARE_HI;
			else             code = OP_PUSH;
		end else begin
			if (r < 50)      code = OP_POP;
			else if (r < 65) code = OP_PUSH;
			else if (r < 78) code = OP_PEEK;
			else if (r < 90) code = OP_SWAP;
			else if (r < 95) code = OP_DUP;
			else if (r < 96) code = OP_CLEAR;
			else if (r < 97) code = OP_SPARE_LO;
			else if (r < 98) code = OP_SPARE_HI;
			else             code = OP_POP;
		end
		k = $urandom_range(9);
		if (k == 0)      word = '0;
		else if (k == 1) word = '1;
		else             word = {$urandom, $urandom};
		send_op(code, TAG_W'($urandom_range(3)), word, pick_index(), pick_index());
	endtask

	// Every operation and the empty and range failure cases on a small stack.
	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// empty stack: underflow and range failures, ignored codes
		send_op(OP_POP,      2'd0, '0, 6'd0,  6'd0);
		send_op(OP_PEEK,     2'd0, '0, 6'd0,  6'd0);
		send_op(OP_DUP,      2'd0, '0, 6'd0,  6'd0);
		send_op(OP_SWAP,     2'd0, '0, 6'd0,  6'd0);
		send_op(OP_SPARE_LO, 2'd3, '1, 6'd63, 6'd63);
		send_op(OP_SPARE_HI, 2'd3, '1, 6'd63, 6'd63);
		// field extremes on push
		send_op(OP_PUSH, 2'd0, '0, 6'd0, 6'd0);
		send_op(OP_PUSH, 2'd3, '1, 6'd63, 6'd63);
		send_op(OP_PUSH, 2'd1, {32{2'b10}}, 6'd0, 6'd0);
		send_op(OP_PUSH, 2'd2, {32{2'b01}}, 6'd0, 6'd0);
		// peek at top, at bottom, one past, and at the largest index
		send_op(OP_PEEK, 2'd0, '0, 6'd0,  6'd0);
		send_op(OP_PEEK, 2'd0, '0, 6'd3,  6'd0);
		send_op(OP_PEEK, 2'd0, '0, 6'd4,  6'd0);
		send_op(OP_PEEK, 2'd0, '0, 6'd63, 6'd0);
		// swap top with bottom, an entry with itself, then out of range
		send_op(OP_SWAP, 2'd0, '0, 6'd0,  6'd3);
		send_op(OP_SWAP, 2'd0, '0, 6'd1,  6'd1);
		send_op(OP_SWAP, 2'd0, '0, 6'd0,  6'd63);
		send_op(OP_SWAP, 2'd0, '0, 6'd63, 6'd0);
		send_op(OP_DUP,  2'd0, '0, 6'd0,  6'd0);
		send_op(OP_POP,  2'd0, '0, 6'd0,  6'd0);
		send_op(OP_POP,  2'd0, '0, 6'd0,  6'd0);
		// clear, then confirm the stack reads as empty
		send_op(OP_CLEAR, 2'd0, '0, 6'd0, 6'd0);
		send_op(OP_POP,   2'd0, '0, 6'd0, 6'd0);
		send_op(OP_PUSH,  2'd1, 64'h0123_4567_89ab_cdef, 6'd0, 6'd0);
		send_op(OP_POP,   2'd0, '0, 6'd0, 6'd0);
		drain_results();
	endtask

	// Alternate fill and drain runs of random length under one idle setting.
	task automatic test_random_phase(
		input int unsigned send_pct,
		input int unsigned recv_pct,
		input int unsigned n_ops
	);
		int unsigned left;
		bit          filling;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		filling = 1'b1;
		left = $urandom_range(200, 60);
		repeat (n_ops) begin
			send_random_op(filling);
			left--;
			if (left == 0) begin
				filling = ~filling;
				left = $urandom_range(200, 60);
			end
		end
		drain_results();
	endtask

	// Hold the receiver off for a long stretch while the sender keeps
	// offering, so the pipeline fills and in_stall rises.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		hold_reqs++;
		repeat (24) send_random_op(1'b1);
		drain_results();
	endtask

	// Receiver: stall at random, or hold off while a forced stretch runs.
	always @(negedge clk) begin
		if (hold_taken != hold_reqs) begin
			hold_taken = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic report_mismatch(
		input string       field,
		input logic [63:0] want,
		input logic [63:0] got
	);
		$display("mismatch on result %0d: %s expected %h got %h",
			results_checked, field, want, got);
		mismatches++;
	endtask

	// Checker: compare each output transaction with the oldest owed result.
	always @(posedge clk) begin
		stack_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, depth", '0, 64'(depth_now));
			end else begin
				want = pending_results.pop_front();
				if (out_tag !== want.tag)
					report_mismatch("out_tag", 64'(want.tag), 64'(out_tag));
				if (out_word !== want.word)
					report_mismatch("out_word", want.word, out_word);
				if (status !== want.st)
					report_mismatch("status", 64'(want.st), 64'(status));
				if (depth_now !== want.depth)
					report_mismatch("depth_now", 64'(want.depth), 64'(depth_now));
			end
			results_checked++;
		end
	end

	// Watchdog: abandon the run after too many cycles with no transaction.
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
		$display("FAIL tagged_operand_stack");
		$finish;
	end

	initial begin
		in_valid = 1'b0;
		op = OP_PUSH;
		value_tag = '0;
		value_word = '0;
		index_a = '0;
		index_b = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_phase(0, 0, 325);
		test_backpressure();
		test_random_phase(87, 0, 325);
		test_random_phase(0, 87, 325);
		test_random_phase(9, 9, 325);

		if (pending_results.size() != 0) begin
			$display("%0d results never arrived", pending_results.size());
		end
		$display("ran %0d operations and checked %0d results across idle and hold-off phases",
			ops_sent, results_checked);
		$display("statuses seen: ok %0d, empty %0d, out of range %0d, full %0d",
			status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_RANGE],
			status_seen[ST_FULL]);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("PASS tagged_operand_stack");
		end else begin
			$display("FAIL tagged_operand_stack");
		end
		$finish;
	end

endmodule
